/* rtl/rpgd_pkg.sv */
// Shared types and constants for the run-length palette glyph decoder.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package rpgd_pkg;

    localparam int RUN_W      = 6;
    localparam int PAL_W      = 2;
    localparam int COLOR_W    = 16;
    localparam int COORD_W    = 11;
    localparam int ROW_W      = 10;
    localparam int GW_W       = 7;
    localparam int POS_W      = 10;
    localparam int CODE_W     = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CODE_W-1:0] RUN_MASK  = 8'h3F;
    localparam logic [PAL_W-1:0]  PAL_MASK  = 2'h3;
    localparam int                PAL_SHIFT = 6;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_GLYPH_WIDTH  = 4'd0;
    localparam cfg_idx_t REG_GLYPH_HEIGHT = 4'd1;
    localparam cfg_idx_t REG_ORIGIN_X     = 4'd2;
    localparam cfg_idx_t REG_ORIGIN_Y     = 4'd3;
    localparam cfg_idx_t REG_PALETTE_0    = 4'd4;
    localparam cfg_idx_t REG_PALETTE_1    = 4'd5;
    localparam cfg_idx_t REG_PALETTE_2    = 4'd6;
    localparam cfg_idx_t REG_PALETTE_3    = 4'd7;

    localparam logic [PAL_W-1:0] PAL_CODE_0 = 2'd0;
    localparam logic [PAL_W-1:0] PAL_CODE_1 = 2'd1;
    localparam logic [PAL_W-1:0] PAL_CODE_2 = 2'd2;
    localparam logic [PAL_W-1:0] PAL_CODE_3 = 2'd3;

    // One decoded run, handed from the front to the back.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [RUN_W-1:0]   run_rem;   // run length minus one
        logic               last_byte; // reset position once the run is done
    } run_item_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

/* rtl/rle_palette_glyph_decoder.sv */
// Top level of the run-length palette glyph decoder: configuration registers,
// front end and back end. Depends on rpgd_pkg, rpgd_front and rpgd_back.
`timescale 1ns / 1ps

// Usage
//   Input queue: drive code_byte and final_byte with push; a byte is taken at
//   a clock edge where push is high and full is low. Bits 7:6 pick a palette
//   color, bits 5:0 plus one give the run length (1 to 64 pixels).
//   Result queue: while empty is low the oldest pixel sits on pixel_color,
//   screen_col, screen_row, row_end and run_last; pop takes it.
//   Configuration: write glyph size, origin and palette through cfg_we,
//   cfg_index and cfg_data, only while no byte is still being expanded.
// Throughput and flow
//   The back end loads a run in its idle state and then emits one pixel per
//   cycle while the result register is free or being popped; it takes the
//   next byte only after the last pixel of the run. A byte that hits a full
//   glyph yields no pixel. A byte passes from the front queue into the back
//   end and then into the result register. The pixel loop of the back end sets this rate.
// Reset
//   rst_n clears both queues, the glyph position and the registers (width
//   and height to one, the rest to zero).
// Stall
//   With pop low the current pixel holds; the back end waits, and the front
//   queue keeps taking bytes until its two entries are filled.

module rle_palette_glyph_decoder #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [rpgd_pkg::CODE_W-1:0]         code_byte,
    input  logic                                final_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [rpgd_pkg::COLOR_W-1:0]        pixel_color,
    output logic [rpgd_pkg::COORD_W-1:0]        screen_col,
    output logic [rpgd_pkg::COORD_W-1:0]        screen_row,
    output logic                                row_end,
    output logic                                run_last,
    input  logic                                cfg_we,
    input  rpgd_pkg::cfg_idx_t                  cfg_index,
    input  logic [rpgd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rpgd_pkg::*;

    logic [GW_W-1:0]    glyph_width_reg, glyph_width_next;
    logic [ROW_W-1:0]   glyph_height_reg, glyph_height_next;
    logic [POS_W-1:0]   origin_x_reg, origin_x_next;
    logic [POS_W-1:0]   origin_y_reg, origin_y_next;
    logic [COLOR_W-1:0] palette_0_reg, palette_0_next;
    logic [COLOR_W-1:0] palette_1_reg, palette_1_next;
    logic [COLOR_W-1:0] palette_2_reg, palette_2_next;
    logic [COLOR_W-1:0] palette_3_reg, palette_3_next;

    logic      q_valid;
    logic      q_pop;
    run_item_t q_item;

    // Register writes: mask to the register width, drop unknown indexes.
    always_comb
    begin
        glyph_width_next  = glyph_width_reg;
        glyph_height_next = glyph_height_reg;
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        palette_0_next    = palette_0_reg;
        palette_1_next    = palette_1_reg;
        palette_2_next    = palette_2_reg;
        palette_3_next    = palette_3_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GLYPH_WIDTH:  glyph_width_next  = cfg_data[GW_W-1:0];
                REG_GLYPH_HEIGHT: glyph_height_next = cfg_data[ROW_W-1:0];
                REG_ORIGIN_X:     origin_x_next     = cfg_data[POS_W-1:0];
                REG_ORIGIN_Y:     origin_y_next     = cfg_data[POS_W-1:0];
                REG_PALETTE_0:    palette_0_next    = cfg_data;
                REG_PALETTE_1:    palette_1_next    = cfg_data;
                REG_PALETTE_2:    palette_2_next    = cfg_data;
                REG_PALETTE_3:    palette_3_next    = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg  <= GW_W'(1);
            glyph_height_reg <= ROW_W'(1);
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            palette_0_reg    <= '0;
            palette_1_reg    <= '0;
            palette_2_reg    <= '0;
            palette_3_reg    <= '0;
        end
        else
        begin
            glyph_width_reg  <= glyph_width_next;
            glyph_height_reg <= glyph_height_next;
            origin_x_reg     <= origin_x_next;
            origin_y_reg     <= origin_y_next;
            palette_0_reg    <= palette_0_next;
            palette_1_reg    <= palette_1_next;
            palette_2_reg    <= palette_2_next;
            palette_3_reg    <= palette_3_next;
        end
    end

    // Front: take bytes, look up the color, queue the run.
    rpgd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .code_byte  (code_byte),
        .final_byte (final_byte),
        .palette_0  (palette_0_reg),
        .palette_1  (palette_1_reg),
        .palette_2  (palette_2_reg),
        .palette_3  (palette_3_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Back: expand each run into pixels and advance the glyph position.
    rpgd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .glyph_width  (glyph_width_reg),
        .glyph_height (glyph_height_reg),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .empty        (empty),
        .pop          (pop),
        .pixel_color  (pixel_color),
        .screen_col   (screen_col),
        .screen_row   (screen_row),
        .row_end      (row_end),
        .run_last     (run_last)
    );

endmodule

/* rtl/rpgd_front.sv */
// Front end: accepts code bytes, decodes them into runs and holds them in a
// two-entry queue for the back end. Depends on rpgd_pkg.
`timescale 1ns / 1ps

module rpgd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [rpgd_pkg::CODE_W-1:0]         code_byte,
    input  logic                                final_byte,
    input  logic [rpgd_pkg::COLOR_W-1:0]        palette_0,
    input  logic [rpgd_pkg::COLOR_W-1:0]        palette_1,
    input  logic [rpgd_pkg::COLOR_W-1:0]        palette_2,
    input  logic [rpgd_pkg::COLOR_W-1:0]        palette_3,
    output logic                                q_valid,
    output rpgd_pkg::run_item_t                 q_item,
    input  logic                                q_pop
);
    import rpgd_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic [PAL_W-1:0]  pal_code;
    run_item_t         item_dec;
    logic              push_ok;
    run_item_t         entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // Classify the byte: palette lookup and run length.
    always_comb
    begin
        pal_code = PAL_W'(code_byte >> PAL_SHIFT) & PAL_MASK;
        item_dec.run_rem   = RUN_W'(code_byte & RUN_MASK);
        item_dec.last_byte = final_byte;
        unique case (pal_code)
            PAL_CODE_0: item_dec.color = palette_0;
            PAL_CODE_1: item_dec.color = palette_1;
            PAL_CODE_2: item_dec.color = palette_2;
            PAL_CODE_3: item_dec.color = palette_3;
            default:    item_dec.color = palette_0;
        endcase
    end

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign push_ok = push && !full;
    assign q_valid = (count_reg != '0);
    assign q_item  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        case ({push_ok, q_pop && q_valid})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entries_reg[wr_ptr_reg] <= item_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/rpgd_back.sv */
// Back end: expands one queued run into pixels, tracks the glyph position and
// drives the result register. Depends on rpgd_pkg.
`timescale 1ns / 1ps

module rpgd_back #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  rpgd_pkg::run_item_t                 q_item,
    output logic                                q_pop,
    input  logic [rpgd_pkg::GW_W-1:0]           glyph_width,
    input  logic [rpgd_pkg::ROW_W-1:0]          glyph_height,
    input  logic [rpgd_pkg::POS_W-1:0]          origin_x,
    input  logic [rpgd_pkg::POS_W-1:0]          origin_y,
    output logic                                empty,
    input  logic                                pop,
    output logic [rpgd_pkg::COLOR_W-1:0]        pixel_color,
    output logic [rpgd_pkg::COORD_W-1:0]        screen_col,
    output logic [rpgd_pkg::COORD_W-1:0]        screen_row,
    output logic                                row_end,
    output logic                                run_last
);
    import rpgd_pkg::*;

    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (EW > GW_W) ? EW : GW_W;

    back_state_t        state_reg, state_next;
    logic [CW-1:0]      column_reg, column_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [RUN_W-1:0]   rem_reg, rem_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               final_reg, final_next;

    logic               out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;
    logic [COORD_W-1:0] out_col_reg, out_col_next;
    logic [COORD_W-1:0] out_row_reg, out_row_next;
    logic               out_row_end_reg, out_row_end_next;
    logic               out_last_reg, out_last_next;

    logic [WW-1:0]      gw_ext;
    logic [WW-1:0]      width_w;
    logic [EW-1:0]      width_eff;
    logic [CW-1:0]      col_clamped;
    logic [EW-1:0]      col_inc;
    logic               end_row;
    logic [COORD_W-1:0] row_inc;
    logic               height_cut;
    logic               can_emit;
    logic               done;

    // Effective width: zero acts as one, anything above MAX_WIDTH is limited.
    always_comb
    begin
        gw_ext = WW'(glyph_width);
        if (gw_ext == '0)
        begin
            width_w = WW'(1);
        end
        else if (gw_ext > WW'(MAX_WIDTH))
        begin
            width_w = WW'(MAX_WIDTH);
        end
        else
        begin
            width_w = gw_ext;
        end
        width_eff = width_w[EW-1:0];
    end

    assign col_clamped = (EW'(column_reg) >= width_eff) ? CW'(width_eff - EW'(1)) : column_reg;
    assign col_inc     = EW'(column_reg) + EW'(1);
    assign end_row     = (col_inc >= width_eff);
    assign row_inc     = COORD_W'(row_reg) + COORD_W'(1);
    assign height_cut  = (row_inc >= COORD_W'(glyph_height));
    assign can_emit    = !out_valid_reg || pop;

    always_comb
    begin
        state_next       = state_reg;
        column_next      = column_reg;
        row_next         = row_reg;
        rem_next         = rem_reg;
        color_next       = color_reg;
        final_next       = final_reg;
        out_valid_next   = out_valid_reg && !pop;
        out_color_next   = out_color_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        out_row_end_next = out_row_end_reg;
        out_last_next    = out_last_reg;
        q_pop            = 1'b0;
        done             = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    color_next  = q_item.color;
                    rem_next    = q_item.run_rem;
                    final_next  = q_item.last_byte;
                    column_next = col_clamped;
                    state_next  = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (row_reg >= glyph_height)
                begin
                    // Glyph full: drop what is left of the run.
                    done = 1'b1;
                end
                else if (can_emit)
                begin
                    out_valid_next   = 1'b1;
                    out_color_next   = color_reg;
                    out_col_next     = COORD_W'(origin_x) + COORD_W'(column_reg);
                    out_row_next     = COORD_W'(origin_y) + COORD_W'(row_reg);
                    out_row_end_next = end_row;
                    out_last_next    = (rem_reg == '0) || (end_row && height_cut);
                    rem_next         = rem_reg - RUN_W'(1);
                    if (end_row)
                    begin
                        column_next = '0;
                        row_next    = row_inc[ROW_W-1:0];
                    end
                    else
                    begin
                        column_next = col_inc[CW-1:0];
                    end
                    done = out_last_next;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (done)
        begin
            state_next = BK_IDLE;
            if (final_reg)
            begin
                column_next = '0;
                row_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            column_reg    <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        color_reg       <= color_next;
        final_reg       <= final_next;
        out_color_reg   <= out_color_next;
        out_col_reg     <= out_col_next;
        out_row_reg     <= out_row_next;
        out_row_end_reg <= out_row_end_next;
        out_last_reg    <= out_last_next;
    end

    assign empty       = !out_valid_reg;
    assign pixel_color = out_color_reg;
    assign screen_col  = out_col_reg;
    assign screen_row  = out_row_reg;
    assign row_end     = out_row_end_reg;
    assign run_last    = out_last_reg;

endmodule

/* rtl/rpgd_checker.sv */
// Port-level checks for the run-length palette glyph decoder, bound to the
// top level. Depends on rpgd_pkg and rle_palette_glyph_decoder.
`timescale 1ns / 1ps

module rpgd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input logic [rpgd_pkg::COLOR_W-1:0]        pixel_color,
    input logic [rpgd_pkg::COORD_W-1:0]        screen_col,
    input logic [rpgd_pkg::COORD_W-1:0]        screen_row,
    input logic                                row_end,
    input logic                                run_last
);
    import rpgd_pkg::*;

    // Held pixel stays put while the receiver stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(pixel_color) && $stable(screen_col)
                           && $stable(screen_row) && $stable(run_last))
        else $error("pixel changed while stalled");

    // Reset leaves both queues drained.
    a_reset: assert property (@(posedge clk)
        !rst_n |-> empty && !full)
        else $error("queues not empty during reset");

    // A run that is not finished delivers its next pixel right away.
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !run_last |=> !empty)
        else $error("run stalled without receiver stall");

    // Inside a row the next pixel of a run sits one column to the right.
    a_step_col: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !run_last && !row_end |=>
            screen_col == COORD_W'($past(screen_col) + COORD_W'(1))
            && screen_row == $past(screen_row))
        else $error("column did not advance by one");

    // After a row ends mid-run the next pixel is one row down.
    a_step_row: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !run_last && row_end |=>
            screen_row == COORD_W'($past(screen_row) + COORD_W'(1)))
        else $error("row did not advance by one");

endmodule

bind rle_palette_glyph_decoder rpgd_checker u_rpgd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .pixel_color (pixel_color),
    .screen_col  (screen_col),
    .screen_row  (screen_row),
    .row_end     (row_end),
    .run_last    (run_last)
);

/* tb/tb_rle_palette_glyph_decoder.sv */
// Self-checking testbench for rle_palette_glyph_decoder: directed and random
// code bytes, with a predictor of the pixel stream. Depends on rpgd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_rle_palette_glyph_decoder;

    import rpgd_pkg::*;

    localparam int MAX_W        = 64;
    localparam int DRAIN_CYCLES = 16;   // drain margin for bytes that yield no pixel, plus queue depth
    localparam int PRESSURE_HOLD = 500; // receiver hold-off that fills the block

    // Index with no register behind it; writes there must change nothing.
    localparam cfg_idx_t REG_SPARE = 4'd12;

    // One pixel as it leaves the block.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               row_end;
        logic               run_last;
    } pixel_t;

    // Predicts the pixel stream from the accepted code bytes and checks
    // every popped pixel against the oldest prediction.
    class glyph_pixel_board;
        logic [GW_W-1:0]    width_reg;
        logic [ROW_W-1:0]   height_reg;
        logic [POS_W-1:0]   org_x;
        logic [POS_W-1:0]   org_y;
        logic [COLOR_W-1:0] palette [4];
        int                 col_pos;
        int                 row_pos;
        pixel_t             pending_pixels [$];
        int                 errors;
        int                 bytes_taken;
        int                 pixels_checked;

        function new();
            width_reg      = 1;
            height_reg     = 1;
            org_x          = 0;
            org_y          = 0;
            foreach (palette[i]) palette[i] = 0;
            col_pos        = 0;
            row_pos        = 0;
            errors         = 0;
            bytes_taken    = 0;
            pixels_checked = 0;
        endfunction

        // Mirror a register write; values are cut to the register width.
        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GLYPH_WIDTH:  width_reg  = data[GW_W-1:0];
                REG_GLYPH_HEIGHT: height_reg = data[ROW_W-1:0];
                REG_ORIGIN_X:     org_x      = data[POS_W-1:0];
                REG_ORIGIN_Y:     org_y      = data[POS_W-1:0];
                REG_PALETTE_0:    palette[0] = data;
                REG_PALETTE_1:    palette[1] = data;
                REG_PALETTE_2:    palette[2] = data;
                REG_PALETTE_3:    palette[3] = data;
                default: ;
            endcase
        endfunction

        // Expand one accepted code byte into its pixels; return how many.
        function int expand_byte(logic [CODE_W-1:0] code, logic last_of_glyph);
            int                 w;
            int                 left;
            int                 produced;
            logic [COLOR_W-1:0] color;
            pixel_t             px;
            w        = (width_reg == 0) ? 1 : int'(width_reg);
            if (w > MAX_W)
                w = MAX_W;
            left     = int'(code & RUN_MASK) + 1;
            color    = palette[(code >> PAL_SHIFT) & PAL_MASK];
            produced = 0;
            bytes_taken++;
            // A narrower width can leave the column past the row end: clamp it.
            if (col_pos >= w)
                col_pos = w - 1;
            while (left > 0 && row_pos < int'(height_reg)) begin
                px.color   = color;
                px.col     = COORD_W'(int'(org_x) + col_pos);
                px.row     = COORD_W'(int'(org_y) + row_pos);
                px.row_end = (col_pos + 1 >= w);
                left--;
                if (px.row_end) begin
                    col_pos = 0;
                    row_pos = (row_pos + 1) & ((1 << ROW_W) - 1);
                end
                else begin
                    col_pos++;
                end
                // Run ends here either by length or because the glyph filled up.
                px.run_last = (left == 0) || (row_pos >= int'(height_reg));
                pending_pixels.push_back(px);
                produced++;
            end
            if (last_of_glyph) begin
                col_pos = 0;
                row_pos = 0;
            end
            return produced;
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel: color %h col %0d row %0d",
                       got.color, got.col, got.row);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.color !== want.color) begin
                $error("pixel_color: expected %h, got %h", want.color, got.color);
                errors++;
            end
            if (got.col !== want.col) begin
                $error("screen_col: expected %0d, got %0d", want.col, got.col);
                errors++;
            end
            if (got.row !== want.row) begin
                $error("screen_row: expected %0d, got %0d", want.row, got.row);
                errors++;
            end
            if (got.row_end !== want.row_end) begin
                $error("row_end: expected %b, got %b", want.row_end, got.row_end);
                errors++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [CODE_W-1:0]     code_byte;
    logic                  final_byte;
    logic                  empty;
    logic                  pop;
    logic [COLOR_W-1:0]    pixel_color;
    logic [COORD_W-1:0]    screen_col;
    logic [COORD_W-1:0]    screen_row;
    logic                  row_end;
    logic                  run_last;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    glyph_pixel_board board = new();

    // Idle and stall rates in percent; the main flow sets them per phase.
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    // Long receiver hold-off requested by the main flow, taken over at a rising edge.
    int hold_req      = 0;
    int settings_used = 0;

    rle_palette_glyph_decoder #(
        .MAX_WIDTH (MAX_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .code_byte   (code_byte),
        .final_byte  (final_byte),
        .empty       (empty),
        .pop         (pop),
        .pixel_color (pixel_color),
        .screen_col  (screen_col),
        .screen_row  (screen_row),
        .row_end     (row_end),
        .run_last    (run_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Build a code byte from a palette code and a run length of 1 to 64.
    function automatic logic [CODE_W-1:0] pack_code(logic [PAL_W-1:0] pal, int len);
        return {pal, RUN_W'(len - 1)};
    endfunction

    // Offer one code byte and hold it until the block takes it. Entered and
    // left at a falling edge; push stays high when the next byte follows at once.
    task automatic send_byte(input logic [CODE_W-1:0] code, input logic last_of_glyph,
                             output int produced);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        code_byte  <= code;
        final_byte <= last_of_glyph;
        @(posedge clk);
        while (full)
            @(posedge clk);
        produced = board.expand_byte(code, last_of_glyph);
        @(negedge clk);
    endtask

    // Drop push, wait for every predicted pixel, then let bytes that
    // expand to nothing drain out of the block before touching registers.
    task automatic wait_drained();
        push <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write all eight registers back to back; only call with the block idle.
    task automatic load_config(input logic [CFG_DATA_W-1:0] w, h, ox, oy, p0, p1, p2, p3);
        cfg_idx_t              regs [8];
        logic [CFG_DATA_W-1:0] vals [8];
        regs = '{REG_GLYPH_WIDTH, REG_GLYPH_HEIGHT, REG_ORIGIN_X, REG_ORIGIN_Y,
                 REG_PALETTE_0, REG_PALETTE_1, REG_PALETTE_2, REG_PALETTE_3};
        vals = '{w, h, ox, oy, p0, p1, p2, p3};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            board.write_reg(regs[i], vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Receiver: decide pop at each falling edge, check the pixel at the
    // rising edge when it is taken. A requested hold-off is counted here.
    initial begin
        int hold_left;
        pixel_t got;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end
            else begin
                pop <= ($urandom_range(0, 99) >= rcv_stall_pct);
            end
            @(posedge clk);
            if (pop && !empty) begin
                got = '{pixel_color, screen_col, screen_row, row_end, run_last};
                board.check_pixel(got);
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
        end
    end

    // Main flow: reset, directed bytes, then random glyphs in four idling modes.
    initial begin
        int                 n;
        int                 got_items;
        int                 glyph_len;
        int                 w;
        int                 h;
        logic               fin;
        push       = 1'b0;
        code_byte  = '0;
        final_byte = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_GLYPH_WIDTH;
        cfg_data   = '0;
        rst_n      = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: one-by-one glyph, black palette. The run of three is
        // cut after one pixel, then the glyph is full and the next byte yields nothing.
        send_byte(pack_code(PAL_CODE_3, 3), 1'b0, n);
        send_byte(pack_code(PAL_CODE_0, 6), 1'b1, n);

        // Eight by three glyph at the far corner; junk above the register
        // widths must be dropped. Runs wrap rows, the long run is cut by the
        // height, and final bytes restart the glyph.
        wait_drained();
        load_config(16'hFF88, 16'hFC03, 16'h03FF, 16'hFFFC,
                    16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A);
        send_byte(pack_code(PAL_CODE_0, 1), 1'b0, n);
        send_byte(pack_code(PAL_CODE_1, 7), 1'b0, n);
        send_byte(pack_code(PAL_CODE_2, 11), 1'b0, n);
        send_byte(pack_code(PAL_CODE_3, 64), 1'b0, n);
        send_byte(pack_code(PAL_CODE_0, 64), 1'b1, n);
        send_byte(pack_code(PAL_CODE_3, 1), 1'b1, n);
        send_byte(pack_code(PAL_CODE_1, 64), 1'b0, n);
        send_byte(pack_code(PAL_CODE_2, 2), 1'b1, n);

        // Width zero acts as one pixel per row.
        wait_drained();
        load_config(16'hFF80, 16'h0005, 16'h0000, 16'h0000,
                    16'h0001, 16'h8000, 16'h7FFE, 16'hFFFF);
        send_byte(pack_code(PAL_CODE_0, 3), 1'b0, n);
        send_byte(pack_code(PAL_CODE_3, 4), 1'b1, n);

        // Width beyond the maximum is limited; tallest glyph, bottom origin.
        wait_drained();
        load_config(16'h007F, 16'h03FF, 16'h0000, 16'h03FF,
                    16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0);
        send_byte(pack_code(PAL_CODE_3, 64), 1'b0, n);
        send_byte(pack_code(PAL_CODE_0, 64), 1'b0, n);
        send_byte(pack_code(PAL_CODE_2, 33), 1'b1, n);

        // Zero height: nothing comes out at all.
        wait_drained();
        load_config(16'h0040, 16'h0000, 16'h0155, 16'h02AA,
                    16'hAAAA, 16'h5555, 16'hC3C3, 16'h3C3C);
        send_byte(pack_code(PAL_CODE_3, 64), 1'b0, n);
        send_byte(pack_code(PAL_CODE_1, 1), 1'b1, n);

        // A write to an unused index must leave every register alone.
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_data  <= 16'hFFFF;
        @(posedge clk);
        board.write_reg(REG_SPARE, 16'hFFFF);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);

        // Narrow the glyph mid-row: the column is pulled back to the new row end.
        load_config(16'h0008, 16'h0004, 16'h0010, 16'h0020,
                    16'h0101, 16'h0202, 16'h0404, 16'h0808);
        send_byte(pack_code(PAL_CODE_1, 6), 1'b0, n);
        wait_drained();
        load_config(16'h0003, 16'h0004, 16'h0010, 16'h0020,
                    16'h0101, 16'h0202, 16'h0404, 16'h0808);
        send_byte(pack_code(PAL_CODE_2, 2), 1'b0, n);
        send_byte(pack_code(PAL_CODE_1, 5), 1'b1, n);

        // Random glyphs: mostly whole glyphs closed by a final byte, some
        // left open or broken up by a stray final byte.
        for (int mode = 0; mode < 4; mode++) begin
            for (int chunk = 0; chunk < 2; chunk++) begin
                wait_drained();
                case ($urandom_range(0, 7))
                    0:       w = 0;
                    1:       w = $urandom_range(MAX_W, 127);
                    2:       w = MAX_W;
                    default: w = $urandom_range(1, 16);
                endcase
                h = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(1, 6);
                load_config((16'($urandom) & 16'hFF80) | 16'(w),
                            (16'($urandom) & 16'hFC00) | 16'(h),
                            16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                case (mode)
                    0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                    1:       begin snd_idle_pct = 81; rcv_stall_pct = 0;  end
                    2:       begin snd_idle_pct = 0;  rcv_stall_pct = 81; end
                    default: begin snd_idle_pct = 19; rcv_stall_pct = 19; end
                endcase
                // Hold the receiver off while bytes keep coming, so full rises.
                if (mode == 0 && chunk == 1)
                    hold_req = PRESSURE_HOLD;
                got_items = 0;
                while (got_items < 10) begin
                    glyph_len = $urandom_range(1, 6);
                    for (int b = 0; b < glyph_len; b++) begin
                        if (b == glyph_len - 1)
                            fin = ($urandom_range(0, 7) != 0);
                        else
                            fin = ($urandom_range(0, 24) == 0);
                        send_byte(8'($urandom), fin, n);
                        got_items++;
                    end
                end
            end
        end

        wait_drained();
        $display("Run covered %0d code bytes and %0d checked pixels over %0d register settings,",
                 board.bytes_taken, board.pixels_checked, settings_used);
        $display("in free-running, sender-idle, receiver-stall and mixed modes with a long hold-off.");
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* rle_palette_glyph_decoder.f */
rtl/rpgd_pkg.sv
rtl/rpgd_front.sv
rtl/rpgd_back.sv
rtl/rle_palette_glyph_decoder.sv
rtl/rpgd_checker.sv
tb/tb_rle_palette_glyph_decoder.sv
